// File: design/fadd_pkg.sv
package fadd_pkg;

   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
   localparam logic [31:0] POS_INF   = 32'h7f80_0000;
   localparam logic [31:0] NEG_INF   = 32'hff80_0000;
   localparam logic [31:0] OPP_INF   = 32'hffc0_0000;
   localparam logic [7:0]  EXP_ONES  = 8'hff;
   localparam logic [7:0]  MAX_GAP   = 8'd24;

   typedef struct packed {
      logic        special;
      logic [31:0] special_bits;
      logic        sign_a;
      logic        sign_b;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [7:0]  eb;
      logic [4:0]  gap;
   } unpack_type;

   typedef struct packed {
      logic        special;
      logic [31:0] special_bits;
      logic [50:0] sum;
      logic [7:0]  eb;
   } align_type;

   typedef struct packed {
      logic        special;
      logic [31:0] special_bits;
      logic        neg;
      logic [48:0] mag;
      logic [5:0]  lead;
      logic [7:0]  eb;
   } lead_type;

   typedef struct packed {
      logic              special;
      logic [31:0]       special_bits;
      logic              neg;
      logic [23:0]       norm;
      logic signed [9:0] exp;
      logic              guard;
      logic              sticky;
   } norm_type;

endpackage

// File: design/fadd_unpack.sv
module fadd_unpack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [31:0]          operand_a,
   input  logic [31:0]          operand_b,
   output logic                 out_valid,
   input  logic                 out_ready,
   output fadd_pkg::unpack_type out_data
);
   import fadd_pkg::*;

   logic       valid_ff;
   unpack_type data_ff;
   unpack_type data_in;
   logic       nan_a;
   logic       nan_b;
   logic       zero_a;
   logic       zero_b;
   logic       swap;
   logic [31:0] big;
   logic [31:0] lit;
   logic [7:0] ea_eff;
   logic [7:0] eb_eff;
   logic [7:0] gap8;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      nan_a  = (operand_a[30:23] == EXP_ONES) && (operand_a[22:0] != 23'd0);
      nan_b  = (operand_b[30:23] == EXP_ONES) && (operand_b[22:0] != 23'd0);
      zero_a = (operand_a == 32'd0) || (operand_a == SIGN_MASK);
      zero_b = (operand_b == 32'd0) || (operand_b == SIGN_MASK);
      swap   = operand_b[30:23] > operand_a[30:23];
      big    = swap ? operand_b : operand_a;
      lit    = swap ? operand_a : operand_b;
      ea_eff = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      eb_eff = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
      gap8   = ea_eff - eb_eff;

      data_in.sign_a = big[31];
      data_in.sign_b = lit[31];
      data_in.ma     = {big[30:23] != 8'd0, big[22:0]};
      data_in.mb     = {lit[30:23] != 8'd0, lit[22:0]};
      data_in.eb     = eb_eff;
      data_in.gap    = gap8[4:0];
      data_in.special      = 1'b1;
      data_in.special_bits = 32'd0;
      priority if (nan_a) begin
         data_in.special_bits = operand_a;
      end else if (nan_b) begin
         data_in.special_bits = operand_b;
      end else if (operand_a == 32'd0 && operand_b == SIGN_MASK) begin
         data_in.special_bits = 32'd0;
      end else if (zero_a) begin
         data_in.special_bits = operand_b;
      end else if (zero_b) begin
         data_in.special_bits = operand_a;
      end else if ((operand_a == POS_INF && operand_b == NEG_INF) ||
                   (operand_a == NEG_INF && operand_b == POS_INF)) begin
         data_in.special_bits = OPP_INF;
      end else if (gap8 > MAX_GAP) begin
         data_in.special_bits = big;
      end else begin
         data_in.special = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: design/fadd_align.sv
module fadd_align (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  fadd_pkg::unpack_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output fadd_pkg::align_type  out_data
);
   import fadd_pkg::*;

   logic        valid_ff;
   align_type   data_ff;
   align_type   data_in;
   logic [50:0] ma_sh;
   logic [50:0] va;
   logic [50:0] vb;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      ma_sh = {27'd0, in_data.ma} << in_data.gap;
      va    = in_data.sign_a ? (51'd0 - ma_sh) : ma_sh;
      vb    = in_data.sign_b ? (51'd0 - {27'd0, in_data.mb}) : {27'd0, in_data.mb};
      data_in.special      = in_data.special;
      data_in.special_bits = in_data.special_bits;
      data_in.sum          = va + vb;
      data_in.eb           = in_data.eb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: design/fadd_lead.sv
module fadd_lead (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  fadd_pkg::align_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output fadd_pkg::lead_type  out_data
);
   import fadd_pkg::*;

   logic        valid_ff;
   lead_type    data_ff;
   lead_type    data_in;
   logic        zero;
   logic [50:0] absv;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      zero = in_data.sum == 51'd0;
      absv = in_data.sum[50] ? (51'd0 - in_data.sum) : in_data.sum;
      data_in.special      = in_data.special || zero;
      data_in.special_bits = in_data.special ? in_data.special_bits : 32'd0;
      data_in.neg          = in_data.sum[50];
      data_in.mag          = absv[48:0];
      data_in.eb           = in_data.eb;
      data_in.lead         = 6'd0;
      for (int i = 0; i < 49; i++) begin
         if (absv[i]) begin
            data_in.lead = 6'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

`ifndef ASSERT_OFF
   a_lead_is_one: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !data_ff.special) |-> data_ff.mag[data_ff.lead])
      else $error("leading-one position does not hold a one");
`endif

endmodule

// File: design/fadd_norm.sv
module fadd_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fadd_pkg::lead_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output fadd_pkg::norm_type out_data
);
   import fadd_pkg::*;

   logic        valid_ff;
   norm_type    data_ff;
   norm_type    data_in;
   logic [5:0]  shamt;
   logic [48:0] x;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      shamt = 6'd48 - in_data.lead;
      x     = in_data.mag << shamt;
      data_in.special      = in_data.special;
      data_in.special_bits = in_data.special_bits;
      data_in.neg          = in_data.neg;
      data_in.norm         = x[48:25];
      data_in.guard        = x[24];
      data_in.sticky       = |x[23:0];
      data_in.exp = $signed({2'b00, in_data.eb} + {4'b0000, in_data.lead} - 10'd23);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: design/fadd_round.sv
module fadd_round (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fadd_pkg::norm_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [31:0]        out_bits
);
   import fadd_pkg::*;

   logic        valid_ff;
   logic [31:0] bits_ff;
   logic [31:0] bits_in;
   logic [9:0]  sub_amt;
   logic [23:0] sub_norm;
   logic        up;
   logic [24:0] rounded;
   logic [7:0]  exp8;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_bits  = bits_ff;

   always_comb begin
      sub_amt  = 10'd1 - in_data.exp;
      sub_norm = in_data.norm >> sub_amt[4:0];
      up       = in_data.guard && (in_data.sticky || in_data.norm[0]);
      rounded  = {1'b0, in_data.norm} + {24'd0, up};
      exp8     = in_data.exp[7:0];
      priority if (in_data.special) begin
         bits_in = in_data.special_bits;
      end else if (in_data.exp <= 10'sd0) begin
         bits_in = {in_data.neg, 8'd0, sub_norm[22:0]};
      end else if (in_data.exp >= 10'sd255) begin
         bits_in = {in_data.neg, EXP_ONES, 23'd0};
      end else if (rounded[24]) begin
         bits_in = {in_data.neg, exp8 + 8'd1, rounded[23:1]};
      end else begin
         bits_in = {in_data.neg, exp8, rounded[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         bits_ff <= bits_in;
      end
   end

`ifndef ASSERT_OFF
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(bits_ff)))
      else $error("stalled result changed or was dropped");
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      (!valid_ff) |-> in_ready)
      else $error("empty output stage refused a beat");
`endif

endmodule

// File: design/single_float_adder_core.sv
// Single-precision floating-point adder.
// The request channel (req_valid, req_ready) carries one beat with two
// single-precision bit patterns, req_operand_a and req_operand_b.
// The response channel (rsp_valid, rsp_ready) returns one beat per request
// with their sum in rsp_sum_bits, rounded to nearest even; subnormal results are truncated.
// The datapath is a five-stage pipeline: unpack and special cases, alignment
// and signed add, absolute value and leading-one search, normalizing shift,
// and rounding with final packing.
// Throughput is one beat per cycle when the receiver is ready.
// Each stage has its own valid bit and accepts a new beat whenever it is
// empty or its contents move on, so a stalled receiver holds the response
// and fills the pipeline behind it without losing or repeating a beat.
// Synchronous reset empties all stages; no other state is kept.
module single_float_adder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sum_bits
);
   import fadd_pkg::*;

   logic       s1_valid;
   logic       s1_ready;
   unpack_type s1_data;
   logic       s2_valid;
   logic       s2_ready;
   align_type  s2_data;
   logic       s3_valid;
   logic       s3_ready;
   lead_type   s3_data;
   logic       s4_valid;
   logic       s4_ready;
   norm_type   s4_data;

   fadd_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   fadd_align u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   fadd_lead u_lead (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   fadd_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (s4_valid),
      .out_ready (s4_ready),
      .out_data  (s4_data)
   );

   fadd_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid),
      .in_ready  (s4_ready),
      .in_data   (s4_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_bits  (rsp_sum_bits)
   );

endmodule
